@@ rtl/yuvc_pkg.sv @@
// ----------------------------------------------------------------------------
// yuvc_pkg
// Shared types, constants and helpers for the YUV to RGB pixel converter.
// ----------------------------------------------------------------------------
package yuvc_pkg;

  localparam int SumW = 20;

  typedef logic signed [SumW-1:0] sum_t;
  typedef logic [7:0]             sample_t;
  typedef logic [1:0]             pos_t;

  // group kind codes
  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_QUAD = 1'b1;

  localparam pos_t POS_LAST_PAIR = 2'd1;
  localparam pos_t POS_LAST_QUAD = 2'd3;

  // bt.601 video range coefficients
  localparam sum_t COEF_Y    = 20'sd298;
  localparam sum_t COEF_R_V  = 20'sd409;
  localparam sum_t COEF_G_U  = 20'sd100;
  localparam sum_t COEF_G_V  = 20'sd208;
  localparam sum_t COEF_B_U  = 20'sd516;
  localparam sum_t Y_OFFSET  = 20'sd16;
  localparam sum_t C_OFFSET  = 20'sd128;
  localparam sum_t ROUND_ADD = 20'sd128;

  localparam sample_t SAMPLE_MAX = 8'd255;

  function automatic sum_t widen(input sample_t s);
    widen = sum_t'({{(SumW-8){1'b0}}, s});
  endfunction

  // floor shift by 8 and clip to 0..255
  function automatic sample_t clip_shift(input sum_t s);
    if (s[SumW-1]) begin
      clip_shift = '0;
    end else if (|s[SumW-2:16]) begin
      clip_shift = SAMPLE_MAX;
    end else begin
      clip_shift = s[15:8];
    end
  endfunction

endpackage

@@ rtl/yuvc_pixel_math.sv @@
// ----------------------------------------------------------------------------
// yuvc_pixel_math
// Converts one luma sample with shared chroma to a clipped RGB pixel.
// ----------------------------------------------------------------------------
module yuvc_pixel_math (
  input  yuvc_pkg::sample_t luma,
  input  yuvc_pkg::sample_t chroma_u,
  input  yuvc_pkg::sample_t chroma_v,
  output yuvc_pkg::sample_t red,
  output yuvc_pkg::sample_t green,
  output yuvc_pkg::sample_t blue
);

  yuvc_pkg::sum_t c;
  yuvc_pkg::sum_t d;
  yuvc_pkg::sum_t e;
  yuvc_pkg::sum_t base;
  yuvc_pkg::sum_t sum_r;
  yuvc_pkg::sum_t sum_g;
  yuvc_pkg::sum_t sum_b;

  always_comb begin
    c     = yuvc_pkg::widen(luma) - yuvc_pkg::Y_OFFSET;
    d     = yuvc_pkg::widen(chroma_u) - yuvc_pkg::C_OFFSET;
    e     = yuvc_pkg::widen(chroma_v) - yuvc_pkg::C_OFFSET;
    base  = yuvc_pkg::COEF_Y * c + yuvc_pkg::ROUND_ADD;
    sum_r = base + yuvc_pkg::COEF_R_V * e;
    sum_g = base - yuvc_pkg::COEF_G_U * d - yuvc_pkg::COEF_G_V * e;
    sum_b = base + yuvc_pkg::COEF_B_U * d;
  end

  assign red   = yuvc_pkg::clip_shift(sum_r);
  assign green = yuvc_pkg::clip_shift(sum_g);
  assign blue  = yuvc_pkg::clip_shift(sum_b);

endmodule

@@ rtl/yuv_to_rgb_pixel_converter_top.sv @@
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_converter_top
// Chroma group to RGB converter, integer bt.601, one pixel/cycle if unstalled.
// ----------------------------------------------------------------------------
//  channel  handshake                   payload
//  group    group_valid / group_ready   kind luma_a..luma_d chroma_u chroma_v
//  pixel    pixel_valid / pixel_ready   red green blue position last
//
//  a pair gives 2 pixels, a quad 4 pixels; unless stalled, the output
//  register takes one pixel per cycle from the group register.
//  a new group is taken in the cycle its predecessor's last pixel moves out.
//  an accepted group's first pixel passes the group and output registers.
//  pixel_ready low holds a valid output register and a full group register.
//  rst clears both valid flags and the pixel counter.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_converter_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              group_valid,
  output logic              group_ready,
  input  logic              kind,
  input  yuvc_pkg::sample_t luma_a,
  input  yuvc_pkg::sample_t luma_b,
  input  yuvc_pkg::sample_t luma_c,
  input  yuvc_pkg::sample_t luma_d,
  input  yuvc_pkg::sample_t chroma_u,
  input  yuvc_pkg::sample_t chroma_v,
  output logic              pixel_valid,
  input  logic              pixel_ready,
  output yuvc_pkg::sample_t red,
  output yuvc_pkg::sample_t green,
  output yuvc_pkg::sample_t blue,
  output yuvc_pkg::pos_t    position,
  output logic              last
);

  // group register
  logic              g_valid;
  logic              g_kind;
  yuvc_pkg::sample_t g_luma [4];
  yuvc_pkg::sample_t g_u;
  yuvc_pkg::sample_t g_v;
  yuvc_pkg::pos_t    g_pos;
  yuvc_pkg::pos_t    g_pos_next;

  logic              group_take;
  logic              out_free;
  logic              pix_load;
  logic              pix_is_last;
  yuvc_pkg::sample_t sel_luma;
  yuvc_pkg::sample_t calc_r;
  yuvc_pkg::sample_t calc_g;
  yuvc_pkg::sample_t calc_b;

  assign out_free    = !pixel_valid || pixel_ready;
  assign pix_load    = g_valid && out_free;
  assign pix_is_last = (g_kind == yuvc_pkg::KIND_QUAD) ? (g_pos == yuvc_pkg::POS_LAST_QUAD)
                                                       : (g_pos == yuvc_pkg::POS_LAST_PAIR);
  assign group_ready = !g_valid || (pix_load && pix_is_last);
  assign group_take  = group_valid && group_ready;
  assign sel_luma    = g_luma[g_pos];

  always_comb begin
    g_pos_next = g_pos;
    if (group_take) begin
      g_pos_next = '0;
    end else if (pix_load) begin
      g_pos_next = g_pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      g_pos   <= '0;
    end else begin
      g_pos <= g_pos_next;
      if (group_take) begin
        g_valid <= 1'b1;
      end else if (pix_load && pix_is_last) begin
        g_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (group_take) begin
      g_kind    <= kind;
      g_luma[0] <= luma_a;
      g_luma[1] <= luma_b;
      g_luma[2] <= luma_c;
      g_luma[3] <= luma_d;
      g_u       <= chroma_u;
      g_v       <= chroma_v;
    end
  end

  yuvc_pixel_math u_math (
    .luma     (sel_luma),
    .chroma_u (g_u),
    .chroma_v (g_v),
    .red      (calc_r),
    .green    (calc_g),
    .blue     (calc_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_free) begin
      pixel_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      red      <= calc_r;
      green    <= calc_g;
      blue     <= calc_b;
      position <= g_pos;
      last     <= pix_is_last;
    end
  end

`ifndef SYNTHESIS
  a_pair_pos: assert property (@(posedge clk) disable iff (rst)
    g_valid && (g_kind == yuvc_pkg::KIND_PAIR) |-> !g_pos[1])
    else $error("pair group pixel counter beyond second pixel");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && last |-> (position == yuvc_pkg::POS_LAST_PAIR) ||
                            (position == yuvc_pkg::POS_LAST_QUAD))
    else $error("last marked on a middle pixel");

  a_take_on_finish: assert property (@(posedge clk) disable iff (rst)
    group_take && g_valid |-> pix_load && pix_is_last)
    else $error("group register overwritten before its last pixel");

  a_group_held: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !last |-> g_valid)
    else $error("group dropped while pixels remain");

  a_pos_reset: assert property (@(posedge clk) disable iff (rst)
    group_take |=> g_pos == '0)
    else $error("pixel counter not restarted on new group");
`endif

endmodule
